FILE: rtl/laplacian_five_point_stencil_top_macros.svh
// Assertion macros shared by the five-point Laplacian stencil RTL.
// Included by the modules that carry concurrent checks; needs nothing else.
`ifndef LAPLACIAN_FIVE_POINT_STENCIL_TOP_MACROS_SVH
`define LAPLACIAN_FIVE_POINT_STENCIL_TOP_MACROS_SVH

// Condition that must hold at every edge outside reset.
`define LAP5_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define LAP5_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define LAP5_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/lap5_pkg.sv
// Shared types and constants for the five-point Laplacian stencil.
// No dependencies; used by every module of the block.
package lap5_pkg;

  localparam int VALUE_W          = 51;
  localparam int IDX_W            = 12;
  localparam int CFG_W            = 13;
  localparam int DIM_MIN          = 3;
  localparam int DIM_RESET        = 64;
  localparam int DEF_MAX_WIDTH    = 4096;
  localparam int DEF_MAX_HEIGHT   = 4096;
  localparam int DEF_SAMPLE_BITS  = 24;
  localparam int QDEPTH           = 8;
  localparam int QPTR_W           = $clog2(QDEPTH);
  localparam int QCNT_W           = $clog2(QDEPTH + 1);
  localparam int OUT_TDATA_W      = ((VALUE_W + 2 * IDX_W + 7) / 8) * 8;
  localparam int OUT_PAD_W        = OUT_TDATA_W - VALUE_W - 2 * IDX_W;

  typedef enum logic {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } cfg_reg_t;

  // Position and kind of the point released by an accepted sample.
  typedef struct packed {
    logic             valid;   // sample releases at least one result
    logic             border;  // released point lies on the grid border
    logic             two;     // last row: own border result follows
    logic [IDX_W-1:0] column;
    logic [IDX_W-1:0] row;     // row of the first released point
  } tap_t;

  // One queue entry: the results released by one sample.
  typedef struct packed {
    logic               two;
    logic [IDX_W-1:0]   column;
    logic [IDX_W-1:0]   row;
    logic [VALUE_W-1:0] value0;
    logic [VALUE_W-1:0] value1;
  } res_pair_t;

endpackage

FILE: rtl/lap5_line_mem.sv
// Simple dual-port line buffer: one write port, one registered read port.
// Uses lap5_pkg only for the default parameter values.
module lap5_line_mem #(
  parameter int DEPTH  = lap5_pkg::DEF_MAX_WIDTH,
  parameter int DATA_W = lap5_pkg::DEF_SAMPLE_BITS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/lap5_calc.sv
// Arithmetic pipeline of the stencil: second differences, scaling, sum.
// Depends on lap5_pkg; feeds lap5_outq with one result pair per point.
module lap5_calc #(
  parameter int SAMPLE_BITS = lap5_pkg::DEF_SAMPLE_BITS,
  parameter int SCALE_W     = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lap5_pkg::tap_t                tap,
  input  logic signed [SAMPLE_BITS-1:0] left,
  input  logic signed [SAMPLE_BITS-1:0] right,
  input  logic signed [SAMPLE_BITS-1:0] up,
  input  logic signed [SAMPLE_BITS-1:0] down,
  input  logic signed [SAMPLE_BITS-1:0] center,
  input  logic [SCALE_W-1:0]            scale_x,
  input  logic [SCALE_W-1:0]            scale_y,
  output logic [1:0]                    inflight,
  output logic                          push,
  output lap5_pkg::res_pair_t           pair
);
  import lap5_pkg::*;

  localparam int DIFF_W = SAMPLE_BITS + 2;
  localparam int PROD_W = DIFF_W + SCALE_W + 1;
  localparam int WIDE_W = (PROD_W + 1 > VALUE_W) ? PROD_W + 1 : VALUE_W;

  tap_t                          tap1, tap2;
  logic signed [DIFF_W-1:0]      dx1, dy1;
  logic signed [SAMPLE_BITS-1:0] c1, c2, s1, s2;
  logic signed [PROD_W-1:0]      px2, py2;
  logic signed [SCALE_W:0]       sxs, sys;
  logic signed [WIDE_W-1:0]      sum;
  logic signed [DIFF_W-1:0]      c_twice;

  assign c_twice = DIFF_W'(center) <<< 1;
  assign sxs     = $signed({1'b0, scale_x});
  assign sys     = $signed({1'b0, scale_y});

  // Stage 1: second differences along x and y.
  always_ff @(posedge clk) begin
    if (rst) begin
      tap1.valid <= 1'b0;
    end else begin
      tap1.valid <= tap.valid;
    end
    tap1.border <= tap.border;
    tap1.two    <= tap.two;
    tap1.column <= tap.column;
    tap1.row    <= tap.row;
    dx1 <= DIFF_W'(left) + DIFF_W'(right) - c_twice;
    dy1 <= DIFF_W'(up) + DIFF_W'(down) - c_twice;
    c1  <= center;
    s1  <= down;
  end

  // Stage 2: scale each difference by (N-1)^2.
  always_ff @(posedge clk) begin
    if (rst) begin
      tap2.valid <= 1'b0;
    end else begin
      tap2.valid <= tap1.valid;
    end
    tap2.border <= tap1.border;
    tap2.two    <= tap1.two;
    tap2.column <= tap1.column;
    tap2.row    <= tap1.row;
    px2 <= dx1 * sxs;
    py2 <= dy1 * sys;
    c2  <= c1;
    s2  <= s1;
  end

  // Final add and border selection go straight into the queue.
  assign sum = WIDE_W'(px2) + WIDE_W'(py2);

  always_comb begin
    pair.two    = tap2.two;
    pair.column = tap2.column;
    pair.row    = tap2.row;
    pair.value0 = tap2.border ? VALUE_W'(c2) : sum[VALUE_W-1:0];
    pair.value1 = VALUE_W'(s2);
  end

  assign push     = tap2.valid;
  assign inflight = {1'b0, tap1.valid} + {1'b0, tap2.valid};

endmodule

FILE: rtl/lap5_outq.sv
// Result queue: holds result pairs and hands them out one transfer at a time.
// Depends on lap5_pkg and the assertion macro header.
`include "laplacian_five_point_stencil_top_macros.svh"
module lap5_outq (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  input  lap5_pkg::res_pair_t                pair,
  output logic [lap5_pkg::QCNT_W-1:0]        level,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata, lowest bit up: value[50:0], column[62:51], row[74:63], zero pad
  output logic [lap5_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                               m_axis_tlast
);
  import lap5_pkg::*;

  res_pair_t         q [QDEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QCNT_W-1:0] count;
  logic              half;    // first result of a two-result entry already sent
  logic              xfer, pop;
  res_pair_t         head;

  assign head          = q[rptr];
  assign xfer          = m_axis_tvalid && m_axis_tready;
  assign pop           = xfer && (!head.two || half);
  assign m_axis_tvalid = (count != '0);
  assign level         = count;

  always_comb begin
    m_axis_tdata = {{OUT_PAD_W{1'b0}},
                    half ? head.row + IDX_W'(1) : head.row,
                    head.column,
                    half ? head.value1 : head.value0};
    m_axis_tlast = head.two ? half : 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= pair;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
      half  <= 1'b0;
    end else begin
      if (push) begin
        wptr <= wptr + QPTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
      if (pop) begin
        half <= 1'b0;
      end else if (xfer) begin
        half <= 1'b1;
      end
    end
  end

  `LAP5_ASSERT_ALWAYS(a_q_bound, clk, rst, count <= QCNT_W'(QDEPTH), "result queue overrun")
  `LAP5_ASSERT_NEXT(a_q_second, clk, rst, xfer && head.two && !half, m_axis_tvalid && half, "second result of a pair lost")

endmodule

FILE: rtl/laplacian_five_point_stencil_top.sv
// Top level of the five-point Laplacian stencil over a raster grid.
// Depends on lap5_pkg, lap5_line_mem, lap5_calc, lap5_outq and the macro header.
//
//   Channel   Signals                              Carries
//   -------   ----------------------------------   -------------------------------
//   s_axis    tvalid tready tdata                  sample u, raster order
//   m_axis    tvalid tready tdata tlast            value, column, row; tlast = last
//   cfg       cfg_we cfg_index cfg_data            grid_width (0), grid_height (1)
//
// One sample is taken per clock while s_axis_tready is high; a sample on any
// row but the last releases at most one result, so the sustained rate is one
// transfer per cycle. On the last row each sample releases two results and the
// single output port sets the pace, sending them one after the other. A result
// passes the difference, multiply and queue stages before it is offered; the
// line buffers are read ahead for the next position. Reset is synchronous
// and clears counters and pipeline valid bits; the line buffers are not cleared.
// s_axis_tready falls only when the result queue has no room left for the items
// already in flight, so a stalled output side back-pressures the input.
`include "laplacian_five_point_stencil_top_macros.svh"
module laplacian_five_point_stencil_top #(
  parameter int MAX_WIDTH   = lap5_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = lap5_pkg::DEF_MAX_HEIGHT,
  parameter int SAMPLE_BITS = lap5_pkg::DEF_SAMPLE_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata, lowest bit up: sample[SAMPLE_BITS-1:0], zero pad to whole bytes
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata, lowest bit up: value[50:0], column[62:51], row[74:63], zero pad
  output logic [lap5_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                             m_axis_tlast,
  input  logic                             cfg_we,
  input  lap5_pkg::cfg_reg_t               cfg_index,
  input  logic [lap5_pkg::CFG_W-1:0]       cfg_data
);
  import lap5_pkg::*;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int SX_W    = 2 * COL_W;
  localparam int SY_W    = 2 * ROW_W;
  localparam int SCALE_W = (SX_W > SY_W) ? SX_W : SY_W;
  localparam int RST_W   = (DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : DIM_RESET;
  localparam int RST_H   = (DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT : DIM_RESET;
  localparam logic [COL_W-1:0]   W_LAST_RST = COL_W'(RST_W - 1);
  localparam logic [ROW_W-1:0]   H_LAST_RST = ROW_W'(RST_H - 1);
  localparam logic [SCALE_W-1:0] SX_RST     = SCALE_W'((RST_W - 1) * (RST_W - 1));
  localparam logic [SCALE_W-1:0] SY_RST     = SCALE_W'((RST_H - 1) * (RST_H - 1));

  // Grid geometry, held as the index of the last column and row.
  logic [COL_W-1:0]   w_last;
  logic [ROW_W-1:0]   h_last;
  logic [SCALE_W-1:0] scale_x, scale_y;
  logic [31:0]        cfg_ext, w_dim, h_dim;
  logic [COL_W-1:0]   w_last_new;
  logic [ROW_W-1:0]   h_last_new;

  // Raster position and the sliding window around the current column.
  logic [COL_W-1:0]              col, col_next;
  logic [ROW_W-1:0]              row, row_next;
  logic signed [SAMPLE_BITS-1:0] sample, center, left, col0;
  logic signed [SAMPLE_BITS-1:0] rd_right, rd_up;
  logic [COL_W-1:0]              addr_right;
  logic                          accept;

  tap_t              tap;
  logic [1:0]        inflight;
  logic              push;
  res_pair_t         pair;
  logic [QCNT_W-1:0] level;

  assign sample = $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
  assign accept = s_axis_tvalid && s_axis_tready;

  // Room must remain in the queue for every pair still in the pipeline plus
  // the one a transfer this cycle would add.
  assign s_axis_tready = ((QCNT_W+1)'(level) + (QCNT_W+1)'(inflight)) < (QCNT_W+1)'(QDEPTH);

  // Out-of-range register values are saturated into the legal dimension range.
  always_comb begin
    cfg_ext = 32'(cfg_data);
    if (cfg_ext < 32'(DIM_MIN)) begin
      w_dim = 32'(DIM_MIN);
      h_dim = 32'(DIM_MIN);
    end else begin
      w_dim = (cfg_ext > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : cfg_ext;
      h_dim = (cfg_ext > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : cfg_ext;
    end
    w_last_new = COL_W'(w_dim - 32'd1);
    h_last_new = ROW_W'(h_dim - 32'd1);
  end

  // The squared step counts are worked out once, at the register write.
  always_ff @(posedge clk) begin
    if (rst) begin
      w_last  <= W_LAST_RST;
      h_last  <= H_LAST_RST;
      scale_x <= SX_RST;
      scale_y <= SY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_WIDTH: begin
          w_last  <= w_last_new;
          scale_x <= SCALE_W'(w_last_new * w_last_new);
        end
        REG_GRID_HEIGHT: begin
          h_last  <= h_last_new;
          scale_y <= SCALE_W'(h_last_new * h_last_new);
        end
        default: begin
          w_last <= w_last;
        end
      endcase
    end
  end

  // Next raster position. A register write restarts the frame at the origin.
  always_comb begin
    col_next = col;
    row_next = row;
    if (rst || cfg_we) begin
      col_next = '0;
      row_next = '0;
    end else if (accept) begin
      if (col == w_last) begin
        col_next = '0;
        row_next = (row == h_last) ? '0 : row + ROW_W'(1);
      end else begin
        col_next = col + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    col <= col_next;
    row <= row_next;
  end

  // The line buffers are read for the position that holds after this edge, so
  // their registered outputs always belong to the current column: the entry to
  // the right in the row above, and the entry of this column two rows up. The
  // write of this cycle never lands on either read address, as the grid has at
  // least three columns.
  assign addr_right = col_next + COL_W'(1);

  lap5_line_mem #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (SAMPLE_BITS)
  ) u_line_above (
    .clk   (clk),
    .we    (accept),
    .waddr (col),
    .wdata (sample),
    .raddr (addr_right),
    .rdata (rd_right)
  );

  // The old centre moves down into the second buffer as the new sample lands.
  lap5_line_mem #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (SAMPLE_BITS)
  ) u_line_two_above (
    .clk   (clk),
    .we    (accept),
    .waddr (col),
    .wdata (center),
    .raddr (col_next),
    .rdata (rd_up)
  );

  // Window registers. The centre of the next column is the entry just read as
  // the right neighbour; at the start of a row it comes from a copy of the
  // first column, which is written whenever that column of the buffer is.
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      center <= col0;
    end else if (accept) begin
      left <= center;
      if (col == '0) begin
        col0 <= sample;
      end
      center <= (col == w_last) ? col0 : rd_right;
    end
  end

  // The sample releases the point one row up; the first row releases nothing.
  always_comb begin
    tap.valid  = accept && (row != '0);
    tap.border = (col == '0) || (row == ROW_W'(1)) || (col == w_last);
    tap.two    = (row == h_last);
    tap.column = IDX_W'(col);
    tap.row    = IDX_W'(row - ROW_W'(1));
  end

  lap5_calc #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .SCALE_W     (SCALE_W)
  ) u_calc (
    .clk      (clk),
    .rst      (rst),
    .tap      (tap),
    .left     (left),
    .right    (rd_right),
    .up       (rd_up),
    .down     (sample),
    .center   (center),
    .scale_x  (scale_x),
    .scale_y  (scale_y),
    .inflight (inflight),
    .push     (push),
    .pair     (pair)
  );

  lap5_outq u_outq (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .pair          (pair),
    .level         (level),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  `LAP5_ASSERT_ALWAYS(a_col_range, clk, rst, (col <= w_last) && (row <= h_last), "raster position beyond grid")
  `LAP5_ASSERT_NEXT(a_cfg_restart, clk, rst, cfg_we, (col == '0) && (row == '0), "register write did not restart frame")
  `LAP5_ASSERT_IMPLY(a_credit, clk, rst, accept, (QCNT_W+1)'(level) + (QCNT_W+1)'(inflight) < (QCNT_W+1)'(QDEPTH), "transfer taken without queue room")

endmodule
